@@ design/wtwm_pkg.sv @@
// shared constants, codes and control types of the wait table
package wtwm_pkg;

	localparam int ACT_W = 3;
	localparam int ID_W = 8;
	localparam int KEY_W = 64;
	localparam int NUM_W = 32;
	localparam int STAT_W = 2;
	localparam int PEND_W = 5;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int WAITER_BITS_DEF = 8;

	localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WAKE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HIT    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MISS   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd5;

	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
	localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic load;
		logic exec;
		logic match;
		logic emit;
	} wtwm_cmd_t;

	typedef struct packed {
		logic is_wake;
		logic out_free;
		logic match_any;
		logic match_last;
	} wtwm_sts_t;

endpackage

@@ design/wtwm_req_if.sv @@
// request channel: one beat carries one table action
interface wtwm_req_if import wtwm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [ID_W-1:0]   waiter_id;
	logic [KEY_W-1:0]  hash;
	logic [KEY_W-1:0]  node_key;

	modport source (output valid, action, waiter_id, hash, node_key, input ready);
	modport sink (input valid, action, waiter_id, hash, node_key, output ready);
endinterface

@@ design/wtwm_rsp_if.sv @@
// result channel: one beat carries one result of a table action
interface wtwm_rsp_if import wtwm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   woken_waiter;
	logic [NUM_W-1:0]  request_number;
	logic              empty_before;
	logic              drained;
	logic              last;
	logic [PEND_W-1:0] pending_count;
	logic [NUM_W-1:0]  queued_total;
	logic [NUM_W-1:0]  served_total;
	logic [NUM_W-1:0]  cancelled_total;
	logic [NUM_W-1:0]  hit_total;
	logic [NUM_W-1:0]  miss_total;

	modport source (output valid, status, woken_waiter, request_number, empty_before, drained,
		last, pending_count, queued_total, served_total, cancelled_total, hit_total,
		miss_total, input ready);
	modport sink (input valid, status, woken_waiter, request_number, empty_before, drained,
		last, pending_count, queued_total, served_total, cancelled_total, hit_total,
		miss_total, output ready);
endinterface

@@ design/wait_table_wakeup_match.sv @@
// top level of the wait table with wake-by-match
// results: enqueue, cancel, count and query each give one result beat, loaded once the output register is free
// wake: match step in the cycle after accept, then one result beat per removed entry (at least one)
// actions: a new action is accepted only once the last one's result beats are loaded; a held beat stalls
// reset: asynchronous active low, empties the table, sets counters to zero and next number to one
module wait_table_wakeup_match import wtwm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int WAITER_BITS = WAITER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [KEY_W-1:0] cfg_wr_data,
	wtwm_req_if.sink         req,
	wtwm_rsp_if.source       rsp
);

	wtwm_cmd_t cmd;
	wtwm_sts_t sts;

	wtwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wtwm_datapath #(
		.DEPTH (TABLE_DEPTH),
		.WBITS (WAITER_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_action    (req.action),
		.in_waiter_id (req.waiter_id),
		.in_hash      (req.hash),
		.in_node_key  (req.node_key),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.sts          (sts),
		.rsp          (rsp)
	);

endmodule

@@ design/wtwm_ctrl.sv @@
// controller: sequences accept, execute, match and emit steps of one action
module wtwm_ctrl import wtwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  wtwm_sts_t sts,
	output wtwm_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WAKE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_wake) begin
					cmd.match = 1'b1;
					state_d = S_WAKE;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WAKE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					// stay while more matched entries remain after this beat
					if (!sts.match_any || sts.match_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_EXEC)
		else $error("accepted beat not followed by execute step");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.emit) |-> sts.out_free)
		else $error("result written while output register occupied");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.match, cmd.emit}))
		else $error("more than one datapath command at once");
`endif

endmodule

@@ design/wtwm_datapath.sv @@
// datapath: packed slot table, match lanes, counters and result register
module wtwm_datapath import wtwm_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int WBITS = WAITER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ACT_W-1:0] in_action,
	input  logic [ID_W-1:0]  in_waiter_id,
	input  logic [KEY_W-1:0] in_hash,
	input  logic [KEY_W-1:0] in_node_key,
	input  logic             cfg_wr_en,
	input  logic [KEY_W-1:0] cfg_wr_data,
	input  wtwm_cmd_t        cmd,
	output wtwm_sts_t        sts,
	wtwm_rsp_if.source       rsp
);

	localparam int IDW = (WBITS < ID_W) ? WBITS : ID_W;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// latched action
	logic [ACT_W-1:0] act_q;
	logic [IDW-1:0]   id_q;
	logic [KEY_W-1:0] hash_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] inv_key_q;

	// slot table, slot 0 oldest
	logic [DEPTH-1:0] vld_q;
	logic [IDW-1:0]   wid_q [DEPTH];
	logic [KEY_W-1:0] hsh_q [DEPTH];
	logic [KEY_W-1:0] nod_q [DEPTH];
	logic [NUM_W-1:0] num_q [DEPTH];
	logic [DEPTH-1:0] match_q;

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] next_q, queued_q, served_q, canc_q, hit_q, miss_q;

	logic             o_valid_q;
	logic [STAT_W-1:0] o_status_q;
	logic [ID_W-1:0]  o_wid_q;
	logic [NUM_W-1:0] o_num_q;
	logic             o_empty_q, o_drained_q, o_last_q;
	logic [PEND_W-1:0] o_pend_q;
	logic [NUM_W-1:0] o_queued_q, o_served_q, o_canc_q, o_hit_q, o_miss_q;

	logic             key_ok;
	logic             id_found;
	logic [IDX_W-1:0] id_idx, fm_idx, sel_idx;
	logic [DEPTH-1:0] m_vec;
	logic [CNT_W-1:0] pc;
	logic [IDW-1:0]   sel_wid;
	logic [NUM_W-1:0] sel_num;
	logic             match_any, match_last, out_free;

	logic             o_load, wr_en, rm_en;
	logic [IDX_W-1:0] rm_idx;
	logic [STAT_W-1:0] n_status;
	logic [ID_W-1:0]  n_wid;
	logic [NUM_W-1:0] n_num;
	logic             n_empty, n_last;
	logic [CNT_W-1:0] n_cnt;
	logic [NUM_W-1:0] n_next, n_queued, n_served, n_canc, n_hit, n_miss;

	assign key_ok = (key_q != '0) && (key_q != inv_key_q);

	// per-slot compare lanes and priority pick of the oldest hit
	always_comb begin
		id_found = 1'b0;
		id_idx = '0;
		fm_idx = '0;
		pc = '0;
		m_vec = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (vld_q[i] && wid_q[i] == id_q) begin
				id_found = 1'b1;
				id_idx = IDX_W'(i);
			end
			if (match_q[i]) begin
				fm_idx = IDX_W'(i);
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			m_vec[i] = vld_q[i] && (hsh_q[i] == hash_q || (key_ok && nod_q[i] == key_q));
			pc = pc + CNT_W'(m_vec[i]);
		end
	end

	assign match_any = |match_q;
	assign match_last = (match_q & (match_q - 1'b1)) == '0;
	assign sel_idx = cmd.emit ? fm_idx : id_idx;
	assign sel_wid = wid_q[sel_idx];
	assign sel_num = num_q[sel_idx];
	assign out_free = !o_valid_q || rsp.ready;

	assign sts.is_wake = (act_q == ACT_WAKE);
	assign sts.out_free = out_free;
	assign sts.match_any = match_any;
	assign sts.match_last = match_last;

	always_comb begin
		o_load = 1'b0;
		wr_en = 1'b0;
		rm_en = 1'b0;
		rm_idx = sel_idx;
		n_status = ST_DONE;
		n_wid = '0;
		n_num = '0;
		n_empty = 1'b0;
		n_last = 1'b1;
		n_cnt = cnt_q;
		n_next = next_q;
		n_queued = queued_q;
		n_served = served_q;
		n_canc = canc_q;
		n_hit = hit_q;
		n_miss = miss_q;
		if (cmd.exec) begin
			o_load = 1'b1;
			case (act_q)
				ACT_ENQ: begin
					n_wid = ID_W'(id_q);
					if (id_found) begin
						n_status = ST_DUP;
						n_num = sel_num;
					end else if (cnt_q == CNT_W'(DEPTH)) begin
						n_status = ST_FULL;
					end else begin
						wr_en = 1'b1;
						n_num = next_q;
						n_empty = (cnt_q == '0);
						n_cnt = cnt_q + 1'b1;
						n_next = next_q + 1'b1;
						n_queued = queued_q + 1'b1;
					end
				end
				ACT_CANCEL: begin
					n_wid = ID_W'(id_q);
					if (id_found) begin
						n_num = sel_num;
						rm_en = 1'b1;
						n_cnt = cnt_q - 1'b1;
						n_canc = canc_q + 1'b1;
					end else begin
						n_status = ST_NONE;
					end
				end
				ACT_HIT: n_hit = hit_q + 1'b1;
				ACT_MISS: n_miss = miss_q + 1'b1;
				default: ;
			endcase
		end else if (cmd.match) begin
			// totals and count move to their final values before the first beat
			n_served = served_q + NUM_W'(pc);
			n_cnt = cnt_q - pc;
		end else if (cmd.emit) begin
			o_load = 1'b1;
			if (match_any) begin
				n_wid = ID_W'(sel_wid);
				n_num = sel_num;
				n_last = match_last;
				rm_en = 1'b1;
			end else begin
				n_status = ST_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			id_q <= in_waiter_id[IDW-1:0];
			hash_q <= in_hash;
			key_q <= in_node_key;
		end
	end

	// slot shift on removal, write at the fill point on enqueue
	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		logic             up_vld;
		logic             up_match;
		logic [IDW-1:0]   up_wid;
		logic [KEY_W-1:0] up_hsh;
		logic [KEY_W-1:0] up_nod;
		logic [NUM_W-1:0] up_num;
		logic             shift;

		if (g < DEPTH - 1) begin : g_up
			assign up_vld = vld_q[g+1];
			assign up_match = match_q[g+1];
			assign up_wid = wid_q[g+1];
			assign up_hsh = hsh_q[g+1];
			assign up_nod = nod_q[g+1];
			assign up_num = num_q[g+1];
		end else begin : g_top
			assign up_vld = 1'b0;
			assign up_match = 1'b0;
			assign up_wid = wid_q[g];
			assign up_hsh = hsh_q[g];
			assign up_nod = nod_q[g];
			assign up_num = num_q[g];
		end

		assign shift = rm_en && (IDX_W'(g) >= rm_idx);

		always_ff @(posedge clk) begin
			if (shift) begin
				wid_q[g] <= up_wid;
				hsh_q[g] <= up_hsh;
				nod_q[g] <= up_nod;
				num_q[g] <= up_num;
			end else if (wr_en && cnt_q[IDX_W-1:0] == IDX_W'(g)) begin
				wid_q[g] <= id_q;
				hsh_q[g] <= hash_q;
				nod_q[g] <= key_q;
				num_q[g] <= next_q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
				match_q[g] <= 1'b0;
			end else begin
				if (shift) begin
					vld_q[g] <= up_vld;
				end else if (wr_en && cnt_q[IDX_W-1:0] == IDX_W'(g)) begin
					vld_q[g] <= 1'b1;
				end
				if (cmd.match) begin
					match_q[g] <= m_vec[g];
				end else if (shift) begin
					match_q[g] <= up_match;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_key_q <= '1;
			cnt_q <= '0;
			next_q <= NUM_W'(1);
			queued_q <= '0;
			served_q <= '0;
			canc_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				inv_key_q <= cfg_wr_data;
			end
			cnt_q <= n_cnt;
			next_q <= n_next;
			queued_q <= n_queued;
			served_q <= n_served;
			canc_q <= n_canc;
			hit_q <= n_hit;
			miss_q <= n_miss;
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_status_q <= n_status;
			o_wid_q <= n_wid;
			o_num_q <= n_num;
			o_empty_q <= n_empty;
			o_drained_q <= (n_cnt == '0);
			o_last_q <= n_last;
			o_pend_q <= PEND_W'(n_cnt);
			o_queued_q <= n_queued;
			o_served_q <= n_served;
			o_canc_q <= n_canc;
			o_hit_q <= n_hit;
			o_miss_q <= n_miss;
		end
	end

	assign rsp.valid = o_valid_q;
	assign rsp.status = o_status_q;
	assign rsp.woken_waiter = o_wid_q;
	assign rsp.request_number = o_num_q;
	assign rsp.empty_before = o_empty_q;
	assign rsp.drained = o_drained_q;
	assign rsp.last = o_last_q;
	assign rsp.pending_count = o_pend_q;
	assign rsp.queued_total = o_queued_q;
	assign rsp.served_total = o_served_q;
	assign rsp.cancelled_total = o_canc_q;
	assign rsp.hit_total = o_hit_q;
	assign rsp.miss_total = o_miss_q;

`ifndef ASSERT_OFF
	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $countones(vld_q) == cnt_q)
		else $error("occupancy count disagrees with valid bits");
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (vld_q & (vld_q + 1'b1)) == '0)
		else $error("held entries not packed from slot zero");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && match_any && match_last) |=> match_q == '0)
		else $error("matched entries left after final wake beat");
`endif

endmodule
